>>> rtl/ds_pkg.sv
// ds_pkg: shared constants and types for the descending sorter.
// No dependencies; compiled first.
package ds_pkg;

  localparam int unsigned CAPACITY = 16;  // cells in the chain, 2..64
  localparam int unsigned VAL_W    = 8;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;  // place the arriving value into the chain
    logic shift;   // move every value one cell toward the output
  } cell_ctl_t;

endpackage

>>> rtl/ds_in_if.sv
// ds_in_if: input channel (value, is_final) with valid/ready.
// Depends on ds_pkg.
interface ds_in_if;
  import ds_pkg::*;

  logic valid;
  logic ready;
  val_t value;
  logic is_final;

  modport source (output valid, output value, output is_final, input ready);
  modport sink   (input valid, input value, input is_final, output ready);
endinterface

>>> rtl/ds_out_if.sv
// ds_out_if: result channel (sorted_value, is_last, overflow) with valid/ready.
// Depends on ds_pkg.
interface ds_out_if;
  import ds_pkg::*;

  logic valid;
  logic ready;
  val_t sorted_value;
  logic is_last;
  logic overflow;

  modport source (output valid, output sorted_value, output is_last, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input is_last, input overflow,
                  output ready);
endinterface

>>> rtl/ds_cell.sv
// ds_cell: one slot of the insertion chain; holds one value and trades with
// its neighbors. Depends on ds_pkg.
module ds_cell (
  input  logic              clk_i,
  input  ds_pkg::cell_ctl_t ctl_i,
  input  ds_pkg::val_t      new_value_i,
  input  logic              occupied_i,
  input  logic              left_greater_i,
  input  ds_pkg::val_t      left_value_i,
  input  ds_pkg::val_t      right_value_i,
  output logic              greater_o,
  output ds_pkg::val_t      value_o
);
  import ds_pkg::*;

  val_t value_q, value_d;

  // new value belongs at or before this cell
  assign greater_o = !occupied_i || (value_q < new_value_i);

  always_comb begin
    value_d = value_q;
    priority if (ctl_i.shift) begin
      value_d = right_value_i;
    end else if (ctl_i.insert && greater_o) begin
      value_d = left_greater_i ? left_value_i : new_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

>>> rtl/descending_sorter.sv
// descending_sorter: top level; fill/emit control around a chain of ds_cell.
// Depends on ds_pkg, ds_in_if, ds_out_if, ds_cell.
//
// Usage:
//   in_i  takes one value per transfer; is_final marks the last of a set.
//   Each value is placed in sorted position in the cell chain in the cycle it
//   is taken, so the input sustains one transfer per cycle while filling.
//   Values arriving with CAPACITY already held are dropped and the set's
//   overflow flag is raised on all of its results.
//   The cycle after the final transfer, out_o shows the largest value; the
//   chain shifts one cell per output transfer. is_last marks the final
//   result. in_i.ready stays low while a set drains, which the emitting
//   flag (emitting_q) sets.
//   A stalled receiver simply holds the chain: the current result stays on
//   out_o until taken. Reset (rst_ni low) empties the chain and clears the
//   overflow flag; cell contents are left as they are and never read.
module descending_sorter (
  input  logic            clk_i,
  input  logic            rst_ni,
  ds_in_if.sink           in_i,
  ds_out_if.source        out_o
);
  import ds_pkg::*;

  logic      emitting_q, emitting_d;
  cnt_t      count_q, count_d;
  logic      dropped_q, dropped_d;
  logic      in_xfer, out_xfer, full;
  cell_ctl_t ctl;

  val_t      cell_value [CAPACITY];
  logic      cell_greater [CAPACITY];

  assign in_i.ready = !emitting_q;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_o.valid && out_o.ready;
  assign full       = (count_q == cnt_t'(CAPACITY));

  assign ctl.insert = in_xfer && !full;
  assign ctl.shift  = out_xfer;

  always_comb begin
    emitting_d = emitting_q;
    count_d    = count_q;
    dropped_d  = dropped_q;
    if (in_xfer) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + cnt_t'(1);
      end
      if (in_i.is_final) begin
        emitting_d = 1'b1;
      end
    end
    if (out_xfer) begin
      count_d = count_q - cnt_t'(1);
      if (out_o.is_last) begin
        emitting_d = 1'b0;
        dropped_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emitting_q <= 1'b0;
      count_q    <= '0;
      dropped_q  <= 1'b0;
    end else begin
      emitting_q <= emitting_d;
      count_q    <= count_d;
      dropped_q  <= dropped_d;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic occupied;
    logic left_greater;
    val_t left_value;
    val_t right_value;

    assign occupied = (count_q > cnt_t'(i));

    if (i == 0) begin : g_head
      assign left_greater = 1'b0;
      assign left_value   = '0;
    end else begin : g_body
      assign left_greater = cell_greater[i-1];
      assign left_value   = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = '0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    ds_cell u_cell (
      .clk_i          (clk_i),
      .ctl_i          (ctl),
      .new_value_i    (in_i.value),
      .occupied_i     (occupied),
      .left_greater_i (left_greater),
      .left_value_i   (left_value),
      .right_value_i  (right_value),
      .greater_o      (cell_greater[i]),
      .value_o        (cell_value[i])
    );
  end

  assign out_o.valid        = emitting_q;
  assign out_o.sorted_value = cell_value[0];
  assign out_o.is_last      = (count_q == cnt_t'(1));
  assign out_o.overflow     = dropped_q;

endmodule

>>> rtl/ds_checker.sv
// ds_checker: port-level checks for descending_sorter, bound to the top.
// Depends on ds_pkg.
module ds_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_ready_i,
  input logic         in_is_final_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input ds_pkg::val_t out_sorted_value_i,
  input logic         out_is_last_i
);
  import ds_pkg::*;

  // no input transfer while a set drains
  a_no_fill_while_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while results pending");

  a_final_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_is_final_i |=> out_valid_i)
    else $error("no result after final transfer");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_is_last_i |=> !out_valid_i)
    else $error("result after last of run");

  // results of one run never increase
  a_descending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_is_last_i |=>
      out_valid_i && (out_sorted_value_i <= $past(out_sorted_value_i)))
    else $error("results not descending");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sorted_value_i))
    else $error("stalled result changed");

endmodule

bind descending_sorter ds_checker u_ds_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .in_is_final_i      (in_i.is_final),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_sorted_value_i (out_o.sorted_value),
  .out_is_last_i      (out_o.is_last)
);
